FILE: hdl/hrrm_pkg.sv
// Shared types and constants for the hash range rule matcher.
package hrrm_pkg;

   localparam int HASH_W    = 32;
   localparam int BOUND_W   = 31;
   localparam int DIV_STEPS = HASH_W;
   localparam int CNT_W     = $clog2(DIV_STEPS);

   localparam logic [3:0] MAX_WORD_OFFSET = 4'd12;

   localparam logic [1:0] KIND_DIGEST = 2'd0;
   localparam logic [1:0] KIND_QUICK  = 2'd1;

   localparam logic MODE_ANY = 1'b0;

   typedef enum logic [1:0] {
      OUT_NO_MATCH = 2'd0,
      OUT_MATCH    = 2'd1,
      OUT_ERROR    = 2'd2
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EVAL,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic eval;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic skip_div;
      logic div_last;
      logic last_rule;
      logic out_busy;
   } dp_status_type;

endpackage

FILE: hdl/hrrm_if.sv
// Rule and result channel interfaces for the hash range rule matcher.
interface hrrm_req_if;
   logic        valid;
   logic        ready;
   logic [63:0] digest_high;
   logic [63:0] digest_low;
   logic [31:0] quick_hash;
   logic [1:0]  rule_kind;
   logic [30:0] range_start;
   logic [30:0] range_end;
   logic [30:0] modulus;
   logic [3:0]  byte_offset;
   logic        match_mode;
   logic        last_rule;

   modport source (
      output valid, digest_high, digest_low, quick_hash, rule_kind, range_start,
             range_end, modulus, byte_offset, match_mode, last_rule,
      input  ready
   );
   modport sink (
      input  valid, digest_high, digest_low, quick_hash, rule_kind, range_start,
             range_end, modulus, byte_offset, match_mode, last_rule,
      output ready
   );
endinterface

interface hrrm_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] outcome;

   modport source (output valid, outcome, input ready);
   modport sink (input valid, outcome, output ready);
endinterface

FILE: hdl/hrrm_ctrl.sv
// Sequencing state machine for the hash range rule matcher.
module hrrm_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  hrrm_pkg::dp_status_type status,
   output hrrm_pkg::ctrl_cmd_type  cmd
);

   hrrm_pkg::ctrl_state_type state_ff;
   hrrm_pkg::ctrl_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= hrrm_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         hrrm_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.skip_div ? hrrm_pkg::ST_EVAL : hrrm_pkg::ST_DIV;
            end
         end
         hrrm_pkg::ST_DIV: begin
            if (status.div_last) begin
               state_in = hrrm_pkg::ST_EVAL;
            end
         end
         hrrm_pkg::ST_EVAL: begin
            state_in = status.last_rule ? hrrm_pkg::ST_EMIT : hrrm_pkg::ST_IDLE;
         end
         hrrm_pkg::ST_EMIT: begin
            if (!status.out_busy) begin
               state_in = hrrm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = hrrm_pkg::ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready    = 1'b0;
      cmd.load     = 1'b0;
      cmd.div_step = 1'b0;
      cmd.eval     = 1'b0;
      cmd.emit     = 1'b0;
      case (state_ff)
         hrrm_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         hrrm_pkg::ST_DIV: begin
            cmd.div_step = 1'b1;
         end
         hrrm_pkg::ST_EVAL: begin
            cmd.eval = 1'b1;
         end
         hrrm_pkg::ST_EMIT: begin
            cmd.emit = !status.out_busy;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

endmodule

FILE: hdl/hrrm_dp.sv
// Datapath: hash select, radix-2 remainder unit, range check, decision and result register.
module hrrm_dp (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [63:0]            req_digest_high,
   input  logic [63:0]            req_digest_low,
   input  logic [31:0]            req_quick_hash,
   input  logic [1:0]             req_rule_kind,
   input  logic [30:0]            req_range_start,
   input  logic [30:0]            req_range_end,
   input  logic [30:0]            req_modulus,
   input  logic [3:0]             req_byte_offset,
   input  logic                   req_match_mode,
   input  logic                   req_last_rule,
   input  hrrm_pkg::ctrl_cmd_type  cmd,
   output hrrm_pkg::dp_status_type status,
   output logic                   rsp_valid,
   output logic [1:0]             rsp_outcome,
   input  logic                   rsp_ready
);

   localparam int HW = hrrm_pkg::HASH_W;
   localparam int BW = hrrm_pkg::BOUND_W;
   localparam int CW = hrrm_pkg::CNT_W;

   logic [HW-1:0]    hash_ff;
   logic [BW-1:0]    rem_ff;
   logic [BW-1:0]    mod_ff;
   logic [BW-1:0]    start_ff;
   logic [BW-1:0]    end_ff;
   logic [CW-1:0]    cnt_ff;
   logic             kind_bad_ff;
   logic             all_mode_ff;
   logic             last_ff;
   logic             decided_ff;
   logic [1:0]       decided_outcome_ff;
   logic [1:0]       pend_ff;
   logic             rsp_valid_ff;
   logic [1:0]       rsp_outcome_ff;

   logic [127:0]     digest_shifted;
   logic [HW-1:0]    word_sel;
   logic [HW-1:0]    hash_in;
   logic             kind_bad_in;
   logic [HW-1:0]    trial;
   logic [BW-1:0]    rem_in;
   logic [HW-1:0]    rem_final;
   logic [HW:0]      bucket;
   logic             hit;
   logic             decided_in;
   logic [1:0]       decided_outcome_in;
   logic [1:0]       pend_in;

   assign digest_shifted = {req_digest_high, req_digest_low} >> {req_byte_offset, 3'b000};
   assign word_sel = (req_byte_offset > hrrm_pkg::MAX_WORD_OFFSET) ? '0 : digest_shifted[HW-1:0];
   assign hash_in = (req_rule_kind == hrrm_pkg::KIND_QUICK) ? req_quick_hash : word_sel;
   assign kind_bad_in = (req_rule_kind != hrrm_pkg::KIND_DIGEST) &&
                        (req_rule_kind != hrrm_pkg::KIND_QUICK);

   assign trial  = {rem_ff, hash_ff[HW-1]};
   assign rem_in = (trial >= {1'b0, mod_ff}) ? BW'(trial - {1'b0, mod_ff}) : trial[BW-1:0];

   assign rem_final = (mod_ff == '0) ? hash_ff : {1'b0, rem_ff};
   assign bucket    = {1'b0, rem_final} + (HW+1)'(1);
   assign hit       = (bucket >= {2'b00, start_ff}) && (bucket <= {2'b00, end_ff});

   always_comb begin
      decided_in         = decided_ff;
      decided_outcome_in = decided_outcome_ff;
      if (!decided_ff) begin
         if (kind_bad_ff) begin
            decided_in         = 1'b1;
            decided_outcome_in = hrrm_pkg::OUT_ERROR;
         end else if (hit && !all_mode_ff) begin
            decided_in         = 1'b1;
            decided_outcome_in = hrrm_pkg::OUT_MATCH;
         end else if (!hit && all_mode_ff) begin
            decided_in         = 1'b1;
            decided_outcome_in = hrrm_pkg::OUT_NO_MATCH;
         end
      end
      if (decided_in) begin
         pend_in = decided_outcome_in;
      end else begin
         pend_in = (all_mode_ff == hrrm_pkg::MODE_ANY) ? hrrm_pkg::OUT_NO_MATCH
                                                        : hrrm_pkg::OUT_MATCH;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         hash_ff     <= hash_in;
         rem_ff      <= '0;
         mod_ff      <= req_modulus;
         start_ff    <= req_range_start;
         end_ff      <= req_range_end;
         cnt_ff      <= CW'(hrrm_pkg::DIV_STEPS - 1);
         kind_bad_ff <= kind_bad_in;
         all_mode_ff <= req_match_mode;
         last_ff     <= req_last_rule;
      end else if (cmd.div_step) begin
         hash_ff <= {hash_ff[HW-2:0], 1'b0};
         rem_ff  <= rem_in;
         cnt_ff  <= cnt_ff - CW'(1);
      end
      if (cmd.eval) begin
         pend_ff <= pend_in;
      end
      if (cmd.emit) begin
         rsp_outcome_ff <= pend_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         decided_ff         <= 1'b0;
         decided_outcome_ff <= hrrm_pkg::OUT_NO_MATCH;
         rsp_valid_ff       <= 1'b0;
      end else begin
         if (cmd.eval) begin
            if (last_ff) begin
               decided_ff         <= 1'b0;
               decided_outcome_ff <= hrrm_pkg::OUT_NO_MATCH;
            end else begin
               decided_ff         <= decided_in;
               decided_outcome_ff <= decided_outcome_in;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign status.skip_div  = decided_ff || kind_bad_in || (req_modulus == '0);
   assign status.div_last  = (cnt_ff == '0);
   assign status.last_rule = last_ff;
   assign status.out_busy  = rsp_valid_ff && !rsp_ready;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_outcome = rsp_outcome_ff;

endmodule

FILE: hdl/hash_range_rule_matcher_top.sv
// Top level of the hash range rule matcher.
// Each rule transfer is taken in the idle state; when its remainder is needed, it then passes
// through the radix-2 restoring remainder unit (one hash bit per cycle, all 32 hash bits) and
// the range judgement. A rule met after the list is already decided, a rule with an invalid
// kind, or a rule with a zero modulus skips the remainder unit. The last rule of a list then
// loads the result register, held off while an earlier result still waits for its transfer;
// the next rule is taken while the result waits there for its transfer.
// Result: 0 no match, 1 match, 2 invalid rule kind.
module hash_range_rule_matcher_top (
   input  logic              clock,
   input  logic              reset,
   hrrm_req_if.sink          req_ch,
   hrrm_rsp_if.source        rsp_ch
);

   hrrm_pkg::ctrl_cmd_type  cmd;
   hrrm_pkg::dp_status_type status;

   hrrm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   hrrm_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_digest_high (req_ch.digest_high),
      .req_digest_low  (req_ch.digest_low),
      .req_quick_hash  (req_ch.quick_hash),
      .req_rule_kind   (req_ch.rule_kind),
      .req_range_start (req_ch.range_start),
      .req_range_end   (req_ch.range_end),
      .req_modulus     (req_ch.modulus),
      .req_byte_offset (req_ch.byte_offset),
      .req_match_mode  (req_ch.match_mode),
      .req_last_rule   (req_ch.last_rule),
      .cmd             (cmd),
      .status          (status),
      .rsp_valid       (rsp_ch.valid),
      .rsp_outcome     (rsp_ch.outcome),
      .rsp_ready       (rsp_ch.ready)
   );

endmodule
